// ===== rtl/crc8fr_pkg.sv =====
// shared types, constants and the crc-8 step for the framed packet receiver
package crc8fr_pkg;

	// frame geometry
	localparam int unsigned MAX_PACKET_LEN = 256;
	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned TAIL_BYTES = 2;
	localparam logic [15:0] MIN_LEN = 16'(HEADER_BYTES + TAIL_BYTES);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_LEN);

	// crc-8 polynomial x^8 + x^2 + x + 1
	localparam logic [7:0] CRC_POLY = 8'h07;

	// header offsets
	localparam logic [8:0] OFS_LEN_LO = 9'd1;
	localparam logic [8:0] OFS_LEN_HI = 9'd2;
	localparam logic [8:0] OFS_HCRC = 9'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_MARK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_MARK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP = 2'd2;

	typedef enum logic [2:0] {
		ST_PROG = 3'd0,
		ST_OK = 3'd1,
		ST_BAD_SD = 3'd2,
		ST_BAD_LEN = 3'd3,
		ST_BAD_HCRC = 3'd4,
		ST_BAD_STOP = 3'd5,
		ST_BAD_PCRC = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_HEAD = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] head_mark;
		logic [7:0] data_mark;
		logic [7:0] stop;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] frame_offset;
		logic       in_frame;
		status_t    status;
		logic [8:0] frame_length;
	} result_t;

	// one byte through the crc, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc8fr_cfg.sv =====
// marker byte registers written through the configuration channel
module crc8fr_cfg import crc8fr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_mark <= 8'd170;
			cfg_q.data_mark <= 8'd85;
			cfg_q.stop <= 8'd13;
		end else if (cfg_valid) begin
			// index beyond the list is dropped
			if (cfg_index == REG_HEAD_MARK) begin
				cfg_q.head_mark <= cfg_data;
			end
			if (cfg_index == REG_DATA_MARK) begin
				cfg_q.data_mark <= cfg_data;
			end
			if (cfg_index == REG_STOP) begin
				cfg_q.stop <= cfg_data;
			end
		end
	end

endmodule

// ===== rtl/crc8fr_core.sv =====
// frame state machine, running crcs and the per-byte result
module crc8fr_core import crc8fr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [8:0]  count_q, count_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  hcrc_q, hcrc_d;
	logic [7:0]  pcrc_q, pcrc_d;
	logic [7:0]  held_q, held_d;

	logic [15:0] idx_ext;
	logic        tail_hit;
	logic        last_byte;
	logic [7:0]  hcrc_in, pcrc_in;
	logic [7:0]  crc_h, crc_p, crc_0;

	assign idx_ext = {7'd0, count_q};
	assign tail_hit = (idx_ext + 16'd2) == len_q;
	assign last_byte = (idx_ext + 16'd1) >= len_q;

	// crc byte is forced to zero where the frame carries its own crc
	assign hcrc_in = (count_q == OFS_HCRC) ? 8'h00 : rx_byte;
	assign pcrc_in = (phase_q == PH_BODY && tail_hit) ? 8'h00 : rx_byte;
	assign crc_h = crc8_step(hcrc_q, hcrc_in);
	assign crc_p = crc8_step(pcrc_q, pcrc_in);
	assign crc_0 = crc8_step(8'h00, rx_byte);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		len_d = len_q;
		hcrc_d = hcrc_q;
		pcrc_d = pcrc_q;
		held_d = held_q;
		res.out_byte = rx_byte;
		res.frame_offset = 8'd0;
		res.in_frame = 1'b0;
		res.status = ST_PROG;
		res.frame_length = 9'd0;

		unique case (phase_q)
			PH_HEAD: begin
				res.frame_offset = count_q[7:0];
				res.in_frame = 1'b1;
				count_d = count_q + 9'd1;
				pcrc_d = crc_p;
				hcrc_d = crc_h;
				if (count_q == OFS_LEN_LO) begin
					len_d = {len_q[15:8], rx_byte};
				end else if (count_q == OFS_LEN_HI) begin
					len_d = {rx_byte, len_q[7:0]};
				end else if (count_q == OFS_HCRC) begin
					held_d = rx_byte;
				end else begin
					// start-data byte closes the header
					phase_d = PH_HUNT;
					if (rx_byte != cfg.data_mark) begin
						res.status = ST_BAD_SD;
					end else if (len_q < MIN_LEN || len_q > MAX_LEN) begin
						res.status = ST_BAD_LEN;
					end else if (held_q != crc_h) begin
						res.status = ST_BAD_HCRC;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				res.frame_offset = count_q[7:0];
				res.in_frame = 1'b1;
				count_d = count_q + 9'd1;
				pcrc_d = crc_p;
				if (tail_hit) begin
					held_d = rx_byte;
				end
				if (last_byte) begin
					phase_d = PH_HUNT;
					if (rx_byte != cfg.stop) begin
						res.status = ST_BAD_STOP;
					end else if (held_d != crc_p) begin
						res.status = ST_BAD_PCRC;
					end else begin
						res.status = ST_OK;
						res.frame_length = len_q[8:0];
					end
				end
			end
			default: begin
				// hunting; stray phase codes fall here too
				phase_d = PH_HUNT;
				if (rx_byte == cfg.head_mark) begin
					phase_d = PH_HEAD;
					count_d = 9'd1;
					len_d = 16'd0;
					hcrc_d = crc_0;
					pcrc_d = crc_0;
					held_d = 8'h00;
					res.in_frame = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 9'd0;
			len_q <= 16'd0;
			hcrc_q <= 8'h00;
			pcrc_q <= 8'h00;
			held_q <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q <= len_d;
			hcrc_q <= hcrc_d;
			pcrc_q <= pcrc_d;
			held_q <= held_d;
		end
	end

endmodule

// ===== rtl/crc8_framed_packet_receiver.sv =====
// top level of the crc-8 framed packet receiver
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  out_byte, frame_offset, in_frame,
//                                              status, frame_length
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte per cycle while in_ready is high: the frame state and both crc-8 steps are
// combinational logic between the frame state registers and the output register
// a byte's result appears in the cycle after its transaction and the next byte
// is taken in that same cycle as long as the output register is empty or drains
// in_ready drops only while a result sits in the output register and out_ready is low
// reset puts the receiver into hunting and loads the default marker bytes
// cfg_ready is always high; the user must change markers only while the receiver is idle, the block does not enforce it
module crc8_framed_packet_receiver import crc8fr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input byte stream
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	// per-byte result
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic [7:0]           frame_offset,
	output logic                 in_frame,
	output logic [2:0]           status,
	output logic [8:0]           frame_length,
	// marker register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	// the output register frees up in the cycle its result is taken
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	crc8fr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crc8fr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.res     (res)
	);

	// output valid tracks whether a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload, loaded on every input transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = res_q.out_byte;
	assign frame_offset = res_q.frame_offset;
	assign in_frame = res_q.in_frame;
	assign status = res_q.status;
	assign frame_length = res_q.frame_length;

endmodule

// ===== tb/sv/crc8_framed_packet_receiver_tb.sv =====
// self-checking testbench for the crc-8 framed packet receiver
`timescale 1ns / 100ps

module crc8_framed_packet_receiver_tb;
	import crc8fr_pkg::*;

	// kinds of frame the stimulus can build
	typedef enum logic [2:0] {
		FAULT_NONE,
		FAULT_START_DATA,
		FAULT_LENGTH,
		FAULT_HEADER_CRC,
		FAULT_STOP,
		FAULT_PACKET_CRC
	} frame_fault_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           out_byte;
	logic [7:0]           frame_offset;
	logic                 in_frame;
	logic [2:0]           status;
	logic [8:0]           frame_length;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = 8'h00;

	crc8_framed_packet_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.frame_offset (frame_offset),
		.in_frame     (in_frame),
		.status       (status),
		.frame_length (frame_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// marker bytes as the receiver should hold them, reset values first
	logic [7:0]  mk_head = 8'd170;
	logic [7:0]  mk_data = 8'd85;
	logic [7:0]  mk_stop = 8'd13;

	// receiver state as predicted
	phase_t      pr_phase = PH_HUNT;
	logic [8:0]  pr_count = '0;
	logic [15:0] pr_len = '0;
	logic [7:0]  pr_hcrc = '0;
	logic [7:0]  pr_pcrc = '0;
	logic [7:0]  pr_held = '0;

	logic [7:0]  byte_stream[$];      // bytes waiting to be offered
	result_t     expected_results[$]; // predictions not yet matched
	int unsigned err_cnt = 0;
	int unsigned bytes_sent = 0;
	int unsigned results_seen = 0;
	int unsigned marker_sets = 1;
	int unsigned status_seen[8];

	// crc-8, poly 0x07, msb first, one byte
	function automatic logic [7:0] crc8_07(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// advance the predicted receiver by one byte and return the byte's result
	function automatic result_t predict_rx_result(input logic [7:0] b);
		result_t    r;
		logic [8:0] idx;
		r.out_byte = b;
		r.frame_offset = 8'h00;
		r.in_frame = 1'b0;
		r.status = ST_PROG;
		r.frame_length = 9'd0;
		idx = pr_count;
		case (pr_phase)
			PH_HEAD: begin
				r.frame_offset = idx[7:0];
				r.in_frame = 1'b1;
				pr_count = pr_count + 9'd1;
				pr_pcrc = crc8_07(pr_pcrc, b);
				if (idx == OFS_LEN_LO) begin
					pr_len[7:0] = b;
					pr_hcrc = crc8_07(pr_hcrc, b);
				end else if (idx == OFS_LEN_HI) begin
					pr_len[15:8] = b;
					pr_hcrc = crc8_07(pr_hcrc, b);
				end else if (idx == OFS_HCRC) begin
					// received header crc is held, the crc itself sees zero
					pr_held = b;
					pr_hcrc = crc8_07(pr_hcrc, 8'h00);
				end else begin
					// start-data position: checks in priority order
					pr_hcrc = crc8_07(pr_hcrc, b);
					pr_phase = PH_HUNT;
					if (b != mk_data)
						r.status = ST_BAD_SD;
					else if (pr_len < MIN_LEN || pr_len > MAX_LEN)
						r.status = ST_BAD_LEN;
					else if (pr_held != pr_hcrc)
						r.status = ST_BAD_HCRC;
					else
						pr_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				r.frame_offset = idx[7:0];
				r.in_frame = 1'b1;
				pr_count = pr_count + 9'd1;
				if (16'(idx) + 16'(TAIL_BYTES) == pr_len) begin
					pr_held = b;
					pr_pcrc = crc8_07(pr_pcrc, 8'h00);
				end else begin
					pr_pcrc = crc8_07(pr_pcrc, b);
				end
				if (16'(idx) + 16'd1 >= pr_len) begin
					// last byte: stop marker before packet crc
					pr_phase = PH_HUNT;
					if (b != mk_stop) begin
						r.status = ST_BAD_STOP;
					end else if (pr_held != pr_pcrc) begin
						r.status = ST_BAD_PCRC;
					end else begin
						r.status = ST_OK;
						r.frame_length = pr_len[8:0];
					end
				end
			end
			default: begin
				// hunting, a failing byte never lands here
				pr_phase = PH_HUNT;
				if (b == mk_head) begin
					pr_phase = PH_HEAD;
					pr_count = 9'd1;
					pr_len = 16'h0000;
					pr_hcrc = crc8_07(8'h00, b);
					pr_pcrc = pr_hcrc;
					pr_held = 8'h00;
					r.in_frame = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [8:0] want,
		input logic [8:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// build one frame with the current markers; len is the length field as sent
	// as_start makes a faulty marker byte equal to the start byte
	task automatic queue_frame(input int unsigned len, input frame_fault_t fault,
		input bit as_start);
		logic [7:0]  fr[$];
		logic [15:0] len_field;
		logic [7:0]  hc;
		logic [7:0]  pc;
		logic [7:0]  flip;
		logic [7:0]  stop_val;
		len_field = 16'(len);
		flip = 8'($urandom_range(1, 255));
		fr.push_back(mk_head);
		fr.push_back(len_field[7:0]);
		fr.push_back(len_field[15:8]);
		hc = 8'h00;
		foreach (fr[i]) hc = crc8_07(hc, fr[i]);
		hc = crc8_07(crc8_07(hc, 8'h00), mk_data);
		fr.push_back(fault == FAULT_HEADER_CRC ? hc ^ flip : hc);
		if (fault != FAULT_START_DATA)
			fr.push_back(mk_data);
		else if (as_start && mk_head != mk_data)
			fr.push_back(mk_head);
		else
			fr.push_back(mk_data ^ flip);
		// body only for frames whose header passes
		if (fault == FAULT_NONE || fault == FAULT_STOP || fault == FAULT_PACKET_CRC) begin
			for (int unsigned i = HEADER_BYTES; i + TAIL_BYTES < len; i++)
				fr.push_back(8'($urandom_range(0, 255)));
			stop_val = mk_stop;
			if (fault == FAULT_STOP)
				stop_val = (as_start && mk_head != mk_stop) ?
					mk_head : mk_stop ^ flip;
			pc = 8'h00;
			foreach (fr[i]) pc = crc8_07(pc, fr[i]);
			pc = crc8_07(crc8_07(pc, 8'h00), stop_val);
			fr.push_back(fault == FAULT_PACKET_CRC ? pc ^ flip : pc);
			fr.push_back(stop_val);
		end
		foreach (fr[i]) byte_stream.push_back(fr[i]);
	endtask

	// mostly small legal lengths, now and then a long one
	function automatic int unsigned pick_len();
		return ($urandom_range(0, 29) == 0) ? $urandom_range(25, MAX_PACKET_LEN) :
			$urandom_range(MIN_LEN, 24);
	endfunction

	// random traffic: mostly good frames, mixed with broken frames and line noise
	task automatic queue_traffic(input int unsigned n_bytes);
		int unsigned  start;
		int unsigned  sel;
		int unsigned  bad_len;
		frame_fault_t fault;
		start = byte_stream.size();
		while (byte_stream.size() - start < n_bytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				queue_frame(pick_len(), FAULT_NONE, 1'b0);
			end else if (sel < 85) begin
				fault = frame_fault_t'($urandom_range(FAULT_START_DATA, FAULT_PACKET_CRC));
				case ($urandom_range(0, 3))
					0: bad_len = $urandom_range(0, MIN_LEN - 1);
					1: bad_len = MAX_PACKET_LEN + 1;
					2: bad_len = 16'hFFFF;
					default: bad_len = $urandom_range(MAX_PACKET_LEN + 1, 16'hFFFF);
				endcase
				queue_frame(fault == FAULT_LENGTH ? bad_len : pick_len(), fault,
					1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 4))
					byte_stream.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// wait until every byte is sent and every result has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (byte_stream.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// rewrite all three markers, one transaction per register
	task automatic write_markers(input logic [7:0] sh, input logic [7:0] sd,
		input logic [7:0] sp);
		logic [CFG_IDX_W-1:0] idx[3];
		logic [7:0]           val[3];
		idx = '{REG_HEAD_MARK, REG_DATA_MARK, REG_STOP};
		val = '{sh, sd, sp};
		@(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk);
			while (!cfg_ready);
			case (idx[i])
				REG_HEAD_MARK: mk_head = val[i];
				REG_DATA_MARK: mk_data = val[i];
				REG_STOP: mk_stop = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		marker_sets++;
		@(negedge clk);
	endtask

	// sender: bursts of random length, random gaps, some bursts back to back
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// the transaction at this edge feeds the predictor
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_rx_result(rx_byte));
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || byte_stream.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					in_valid <= 1'b1;
					rx_byte <= byte_stream.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: stall pattern picked at random from three modes, plus a long
	// hold-off every 400 results while the sender is still offering bytes
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 400;
	int unsigned rdy_mode = 0;
	int unsigned rdy_cnt = 0;

	always @(posedge clk) begin
		result_t r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result for byte %0d arrived with nothing expected", out_byte);
					err_cnt++;
				end else begin
					r = expected_results.pop_front();
					status_seen[r.status]++;
					check_field("out_byte", 9'(r.out_byte), 9'(out_byte));
					check_field("frame_offset", 9'(r.frame_offset), 9'(frame_offset));
					check_field("in_frame", 9'(r.in_frame), 9'(in_frame));
					check_field("status", 9'(r.status), 9'(status));
					check_field("frame_length", r.frame_length, frame_length);
				end
			end
			rdy_cnt++;
			if (rdy_cnt % 64 == 0)
				rdy_mode = $urandom_range(0, 2);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= next_hold_at && in_valid) begin
				// long back-pressure so the output register fills and in_ready drops
				hold_left = 120;
				next_hold_at += 400;
				out_ready <= 1'b0;
			end else begin
				case (rdy_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset markers: line noise, then one frame per outcome
		byte_stream.push_back(8'h00);
		byte_stream.push_back(8'hFF);
		queue_frame(MIN_LEN, FAULT_NONE, 1'b0);
		queue_frame(MIN_LEN, FAULT_START_DATA, 1'b1); // failing byte is the start byte
		queue_frame(MIN_LEN - 1, FAULT_LENGTH, 1'b0);
		queue_frame(MIN_LEN, FAULT_HEADER_CRC, 1'b0);
		queue_frame(MIN_LEN, FAULT_STOP, 1'b1);
		queue_frame(MIN_LEN, FAULT_PACKET_CRC, 1'b0);
		wait_drained();

		// extreme markers, start and stop the same
		write_markers(8'h00, 8'hFF, 8'h00);
		queue_traffic(180);
		wait_drained();

		// all three markers equal, plus the longest frames
		write_markers(8'hFF, 8'hFF, 8'hFF);
		queue_frame(MAX_PACKET_LEN, FAULT_NONE, 1'b0);
		queue_traffic(130);
		queue_frame(MAX_PACKET_LEN - 1, FAULT_PACKET_CRC, 1'b0);
		wait_drained();

		write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		queue_traffic(180);
		wait_drained();

		write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		queue_traffic(150);
		wait_drained();

		$display("run covered %0d bytes under %0d marker settings", bytes_sent, marker_sets);
		$display("accepted %0d, bad start-data %0d, length %0d, hcrc %0d, stop %0d, pcrc %0d",
			status_seen[ST_OK], status_seen[ST_BAD_SD], status_seen[ST_BAD_LEN],
			status_seen[ST_BAD_HCRC], status_seen[ST_BAD_STOP], status_seen[ST_BAD_PCRC]);
		if (err_cnt == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== crc8_framed_packet_receiver.f =====
rtl/crc8fr_pkg.sv
rtl/crc8fr_cfg.sv
rtl/crc8fr_core.sv
rtl/crc8_framed_packet_receiver.sv
tb/sv/crc8_framed_packet_receiver_tb.sv
